// ===== hw/rtl/lmt_pkg.sv =====
// Shared types and constants for the display mode and line timer.
// Used by lmt_core, lcd_mode_line_timer and the port checker.
package lmt_pkg;

  // Mode codes as seen on the result port
  localparam logic [1:0] CODE_HBLANK = 2'd0;
  localparam logic [1:0] CODE_VBLANK = 2'd1;
  localparam logic [1:0] CODE_OAM    = 2'd2;
  localparam logic [1:0] CODE_XFER   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_LYC       = 2'd0;
  localparam logic [1:0] REG_HBLANK_IE = 2'd1;
  localparam logic [1:0] REG_VBLANK_IE = 2'd2;
  localparam logic [1:0] REG_OAM_IE    = 2'd3;

  // Request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Timing constants
  localparam logic [9:0] HBLANK_LEN        = 10'd207;
  localparam logic [9:0] OAM_LEN           = 10'd83;
  localparam logic [9:0] XFER_LEN          = 10'd175;
  localparam logic [9:0] VLINE_LEN         = 10'd456;
  localparam logic [9:0] ACCUM_MAX         = 10'd1023;
  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE         = 8'd152;

  typedef enum logic [3:0] {
    MODE_HBLANK = 4'b0001,
    MODE_VBLANK = 4'b0010,
    MODE_OAM    = 4'b0100,
    MODE_XFER   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] cycles;
    logic       irq_master_enable;
    logic       lcd_enable_value;
  } item_t;

  typedef struct packed {
    logic [7:0] lyc_compare;
    logic       hblank_irq_enable;
    logic       vblank_irq_enable;
    logic       oam_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       lyc_match;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_done;
  } result_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] code;
    case (m)
      MODE_HBLANK: code = CODE_HBLANK;
      MODE_VBLANK: code = CODE_VBLANK;
      MODE_OAM:    code = CODE_OAM;
      MODE_XFER:   code = CODE_XFER;
      default:     code = CODE_OAM;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/lmt_core.sv =====
// Mode, line and cycle counter state with its single step update.
// Depends on lmt_pkg for the item, configuration and result types.
module lmt_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  lmt_pkg::item_t   item,
  input  lmt_pkg::cfg_t    cfg,
  output lmt_pkg::result_t res
);
  import lmt_pkg::*;

  mode_t      mode_state, mode_state_next;
  logic [9:0] cycle_accum, cycle_accum_next;
  logic [7:0] line_count, line_count_next;
  logic       display_enabled, display_enabled_next;
  logic       match_flag, match_flag_next;

  logic [10:0] accum_sum;
  logic [9:0]  accum_sat;
  logic [9:0]  phase_len;
  logic        phase_done;
  logic [9:0]  accum_rem;
  logic [7:0]  line_inc;
  logic        line_match;
  logic        vb_irq, st_irq, done;

  always_comb begin
    accum_sum  = {1'b0, cycle_accum} + {3'b000, item.cycles};
    accum_sat  = accum_sum[10] ? ACCUM_MAX : accum_sum[9:0];
    case (mode_state)
      MODE_HBLANK: phase_len = HBLANK_LEN;
      MODE_OAM:    phase_len = OAM_LEN;
      MODE_XFER:   phase_len = XFER_LEN;
      default:     phase_len = VLINE_LEN;
    endcase
    phase_done = accum_sat >= phase_len;
    accum_rem  = accum_sat - phase_len;
    line_inc   = (line_count == LAST_LINE) ? 8'd0 : line_count + 8'd1;
    line_match = line_inc == cfg.lyc_compare;

    mode_state_next      = mode_state;
    cycle_accum_next     = cycle_accum;
    line_count_next      = line_count;
    display_enabled_next = display_enabled;
    match_flag_next      = match_flag;
    vb_irq = 1'b0;
    st_irq = 1'b0;
    done   = 1'b0;

    if (item.req_type == REQ_WRITE) begin
      // a rising enable resets the line to 0 and clears the cycle counter
      if (item.lcd_enable_value && !display_enabled) begin
        line_count_next  = 8'd0;
        cycle_accum_next = 10'd0;
      end
      display_enabled_next = item.lcd_enable_value;
    end else if (display_enabled) begin
      cycle_accum_next = phase_done ? accum_rem : accum_sat;
      if (phase_done) begin
        case (mode_state)
          MODE_HBLANK: begin
            done            = 1'b1;
            line_count_next = line_inc;
            match_flag_next = line_match;
            if (line_inc == FIRST_VBLANK_LINE) begin
              mode_state_next = MODE_VBLANK;
              vb_irq          = 1'b1;
              st_irq          = item.irq_master_enable &&
                                (line_match || cfg.vblank_irq_enable);
            end else begin
              mode_state_next = MODE_OAM;
              st_irq          = item.irq_master_enable &&
                                (line_match || cfg.oam_irq_enable);
            end
          end
          MODE_OAM: begin
            mode_state_next = MODE_XFER;
          end
          MODE_XFER: begin
            mode_state_next = MODE_HBLANK;
            st_irq          = item.irq_master_enable && cfg.hblank_irq_enable;
          end
          default: begin
            line_count_next = line_inc;
            match_flag_next = line_match;
            if (line_inc == 8'd0) begin
              mode_state_next = MODE_OAM;
              st_irq          = item.irq_master_enable &&
                                (line_match || cfg.oam_irq_enable);
            end else begin
              st_irq = item.irq_master_enable && line_match;
            end
          end
        endcase
      end
    end

    res.mode       = mode_code(mode_state_next);
    res.line       = line_count_next;
    res.lyc_match  = match_flag_next;
    res.vblank_irq = vb_irq;
    res.stat_irq   = st_irq;
    res.line_done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state      <= MODE_OAM;
      cycle_accum     <= 10'd0;
      line_count      <= 8'd0;
      display_enabled <= 1'b1;
      match_flag      <= 1'b0;
    end else if (advance) begin
      mode_state      <= mode_state_next;
      cycle_accum     <= cycle_accum_next;
      line_count      <= line_count_next;
      display_enabled <= display_enabled_next;
      match_flag      <= match_flag_next;
    end
  end

endmodule

// ===== hw/rtl/lcd_mode_line_timer.sv =====
// Display controller mode and line timer: use notes below.
// Top level; depends on lmt_pkg and lmt_core.
//
// Items arrive on the in channel (in_valid/in_ready): a tick carries elapsed
// cycles, a control write carries the display enable bit. Every item gives
// exactly one result on the out channel (out_valid/out_ready): mode, line,
// match flag and the vblank, stat and line-done pulses for that item.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes are expected only while
// the block is idle.
// The item sits in the input register after the edge that accepts it, and on
// advance the state update lands in the result register and raises out_valid.
// One item per cycle is sustained while the receiver takes results; the only
// loop is the counter and mode update.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until the result is taken.
// Reset leaves the timer in oam search at line 0 with the display enabled,
// clears cfg, the cycle counter and the match flag, and empties both stages.
module lcd_mode_line_timer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] cycles,
  input  logic       irq_master_enable,
  input  logic       lcd_enable_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] mode,
  output logic [7:0] line,
  output logic       lyc_match,
  output logic       vblank_irq,
  output logic       stat_irq,
  output logic       line_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import lmt_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  logic    advance;
  result_t step_res;
  result_t res;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LYC:       cfg.lyc_compare       <= cfg_data;
        REG_HBLANK_IE: cfg.hblank_irq_enable <= cfg_data[0];
        REG_VBLANK_IE: cfg.vblank_irq_enable <= cfg_data[0];
        REG_OAM_IE:    cfg.oam_irq_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.req_type          <= req_type;
      in_item.cycles            <= cycles;
      in_item.irq_master_enable <= irq_master_enable;
      in_item.lcd_enable_value  <= lcd_enable_value;
    end
  end

  lmt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (step_res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign mode       = res.mode;
  assign line       = res.line;
  assign lyc_match  = res.lyc_match;
  assign vblank_irq = res.vblank_irq;
  assign stat_irq   = res.stat_irq;
  assign line_done  = res.line_done;

endmodule

// ===== hw/rtl/lmt_checker.sv =====
// Port-level checks for lcd_mode_line_timer, attached by bind.
// Depends on lmt_pkg for the mode codes.
module lmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] mode,
  input logic [7:0] line,
  input logic       vblank_irq,
  input logic       line_done
);
  import lmt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(line))
    else $error("result changed while stalled");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line <= LAST_LINE)
    else $error("line beyond last line");

  // visible lines never show in vblank-only line numbers
  a_mode_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode != CODE_VBLANK |-> line < FIRST_VBLANK_LINE)
    else $error("active mode on a vblank line");

  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |->
      mode == CODE_VBLANK && line == FIRST_VBLANK_LINE && line_done)
    else $error("vblank pulse away from vblank entry");

  a_line_done_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> mode == CODE_OAM || mode == CODE_VBLANK)
    else $error("line done without a line change");

endmodule

bind lcd_mode_line_timer lmt_checker u_lmt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .mode       (mode),
  .line       (line),
  .vblank_irq (vblank_irq),
  .line_done  (line_done)
);

// ===== test/lcd_mode_line_timer_tb.sv =====
// Testbench for lcd_mode_line_timer: a directed table, then random ticks and control writes.
// Depends on lmt_pkg; results are checked against a local timer model or typed table rows.
`timescale 1ns / 1ps

module lcd_mode_line_timer_tb;
  import lmt_pkg::*;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    item_t      it;
    logic [3:0] reps;
    logic       typed;
    result_t    want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       req_type = REQ_TICK;
  logic [7:0] cycles = 8'd0;
  logic       irq_master_enable = 1'b0;
  logic       lcd_enable_value = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] mode;
  logic [7:0] line;
  logic       lyc_match;
  logic       vblank_irq;
  logic       stat_irq;
  logic       line_done;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_LYC;
  logic [7:0] cfg_data = 8'd0;

  // Timer state as left by reset
  logic [1:0] tm_mode = CODE_OAM;
  logic [9:0] tm_accum = 10'd0;
  logic [7:0] tm_line = 8'd0;
  logic       tm_lcd_on = 1'b1;
  logic       tm_match = 1'b0;
  cfg_t       tm_cfg = '0;

  result_t expected_q[$];
  int      fail_count = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  bit      stall_req = 1'b0;

  lcd_mode_line_timer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .cycles(cycles),
    .irq_master_enable(irq_master_enable), .lcd_enable_value(lcd_enable_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .mode(mode), .line(line), .lyc_match(lyc_match),
    .vblank_irq(vblank_irq), .stat_irq(stat_irq), .line_done(line_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the timer by one item and return the result it should show
  function automatic result_t step_timer(item_t it);
    result_t     r;
    logic [10:0] sum;
    logic        ime;
    r = '0;
    ime = it.irq_master_enable;
    if (it.req_type == REQ_WRITE) begin
      if (it.lcd_enable_value && !tm_lcd_on) begin
        tm_line = 8'd0;
        tm_accum = 10'd0;
      end
      tm_lcd_on = it.lcd_enable_value;
    end else if (tm_lcd_on) begin
      sum = {1'b0, tm_accum} + {3'b000, it.cycles};
      tm_accum = (sum > {1'b0, ACCUM_MAX}) ? ACCUM_MAX : sum[9:0];
      case (tm_mode)
        CODE_HBLANK: begin
          if (tm_accum >= HBLANK_LEN) begin
            tm_accum = tm_accum - HBLANK_LEN;
            r.line_done = 1'b1;
            tm_line = (tm_line == LAST_LINE) ? 8'd0 : tm_line + 8'd1;
            tm_match = (tm_line == tm_cfg.lyc_compare);
            r.stat_irq = tm_match & ime;
            if (tm_line == FIRST_VBLANK_LINE) begin
              tm_mode = CODE_VBLANK;
              r.vblank_irq = 1'b1;
              r.stat_irq = r.stat_irq | (tm_cfg.vblank_irq_enable & ime);
            end else begin
              tm_mode = CODE_OAM;
              r.stat_irq = r.stat_irq | (tm_cfg.oam_irq_enable & ime);
            end
          end
        end
        CODE_OAM: begin
          if (tm_accum >= OAM_LEN) begin
            tm_accum = tm_accum - OAM_LEN;
            tm_mode = CODE_XFER;
          end
        end
        CODE_XFER: begin
          if (tm_accum >= XFER_LEN) begin
            tm_accum = tm_accum - XFER_LEN;
            tm_mode = CODE_HBLANK;
            r.stat_irq = tm_cfg.hblank_irq_enable & ime;
          end
        end
        default: begin
          if (tm_accum >= VLINE_LEN) begin
            tm_accum = tm_accum - VLINE_LEN;
            tm_line = (tm_line == LAST_LINE) ? 8'd0 : tm_line + 8'd1;
            tm_match = (tm_line == tm_cfg.lyc_compare);
            r.stat_irq = tm_match & ime;
            if (tm_line == 8'd0) begin
              tm_mode = CODE_OAM;
              r.stat_irq = r.stat_irq | (tm_cfg.oam_irq_enable & ime);
            end
          end
        end
      endcase
    end
    r.mode = tm_mode;
    r.line = tm_line;
    r.lyc_match = tm_match;
    return r;
  endfunction

  function automatic row_t tick_row(logic [7:0] c, logic ime, int n);
    row_t r;
    r = '0;
    r.it.req_type = REQ_TICK;
    r.it.cycles = c;
    r.it.irq_master_enable = ime;
    r.reps = n[3:0];
    return r;
  endfunction

  function automatic row_t write_row(logic en);
    row_t r;
    r = '0;
    r.it.req_type = REQ_WRITE;
    r.it.cycles = 8'hff;
    r.it.irq_master_enable = 1'b1;
    r.it.lcd_enable_value = en;
    r.reps = 4'd1;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [7:0] v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  function automatic row_t with_result(row_t r, logic [1:0] m, logic [7:0] ln, int mt,
                                       int vb, int st, int dn);
    row_t o;
    o = r;
    o.typed = 1'b1;
    o.want = {m, ln, mt[0], vb[0], st[0], dn[0]};
    return o;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.cycles = 8'($urandom_range(255));
    it.irq_master_enable = 1'($urandom_range(1));
    it.lcd_enable_value = 1'($urandom_range(1));
    pick = $urandom_range(999);
    // a disabled display gets re-enabled soon; otherwise writes are rare noise
    if (tm_lcd_on ? (pick < 4) : (pick < 300)) begin
      it.req_type = REQ_WRITE;
    end else begin
      it.req_type = REQ_TICK;
      pick = $urandom_range(99);
      if (pick < 70)
        it.cycles = 8'($urandom_range(255, 220));
      else if (pick < 78)
        it.cycles = 8'd0;
      else if (pick < 86)
        it.cycles = 8'hff;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic use_typed, input result_t typed_res);
    result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req_type;
    cycles <= it.cycles;
    irq_master_enable <= it.irq_master_enable;
    lcd_enable_value <= it.lcd_enable_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = step_timer(it);
    expected_q.push_back(use_typed ? typed_res : pred);
  endtask

  // Drop valid and hold until every result is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LYC:       tm_cfg.lyc_compare = v;
      REG_HBLANK_IE: tm_cfg.hblank_irq_enable = v[0];
      REG_VBLANK_IE: tm_cfg.vblank_irq_enable = v[0];
      default:       tm_cfg.oam_irq_enable = v[0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random back-pressure, or a long hold-off when asked
  initial begin
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {mode, line, lyc_match, vblank_irq, stat_irq, line_done};
      if (expected_q.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: mode %0d line %0d", got.mode, got.line);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.mode !== want.mode || got.line !== want.line ||
            got.lyc_match !== want.lyc_match || got.vblank_irq !== want.vblank_irq ||
            got.stat_irq !== want.stat_irq || got.line_done !== want.line_done) begin
          if (fail_count < 10) begin
            $display("mismatch: want mode %0d line %0d match %b vb %b stat %b done %b",
                     want.mode, want.line, want.lyc_match, want.vblank_irq, want.stat_irq,
                     want.line_done);
            $display("          got  mode %0d line %0d match %b vb %b stat %b done %b",
                     got.mode, got.line, got.lyc_match, got.vblank_irq, got.stat_irq,
                     got.line_done);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    row_t       dir_rows[$];
    row_t       row;
    item_t      it;
    int         counted;
    logic [7:0] lyc_val;
    logic [2:0] ie;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    dir_rows.push_back(with_result(tick_row(8'd0, 1'b0, 1), CODE_OAM, 8'd0, 0, 0, 0, 0));
    dir_rows.push_back(with_result(tick_row(8'd82, 1'b1, 1), CODE_OAM, 8'd0, 0, 0, 0, 0));
    dir_rows.push_back(with_result(tick_row(8'd1, 1'b0, 1), CODE_XFER, 8'd0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(REG_HBLANK_IE, 8'd1));
    dir_rows.push_back(with_result(tick_row(8'd255, 1'b1, 1), CODE_HBLANK, 8'd0, 0, 0, 1, 0));
    dir_rows.push_back(cfg_row(REG_LYC, 8'd1));
    dir_rows.push_back(cfg_row(REG_OAM_IE, 8'd1));
    // line match with ime clear: flag set, no stat pulse
    dir_rows.push_back(with_result(tick_row(8'd255, 1'b0, 1), CODE_OAM, 8'd1, 1, 0, 0, 1));
    dir_rows.push_back(with_result(write_row(1'b0), CODE_OAM, 8'd1, 1, 0, 0, 0));
    dir_rows.push_back(with_result(tick_row(8'd255, 1'b1, 1), CODE_OAM, 8'd1, 1, 0, 0, 0));
    // rising enable clears line and counter but keeps the match flag
    dir_rows.push_back(with_result(write_row(1'b1), CODE_OAM, 8'd0, 1, 0, 0, 0));
    dir_rows.push_back(write_row(1'b1));
    // new compare value only takes effect at the next line change
    dir_rows.push_back(cfg_row(REG_LYC, 8'd2));
    dir_rows.push_back(tick_row(8'd255, 1'b1, 9));
    dir_rows.push_back(cfg_row(REG_VBLANK_IE, 8'd1));
    dir_rows.push_back(tick_row(8'd0, 1'b0, 1));
    row = tick_row(8'd255, 1'b0, 2);
    row.it.lcd_enable_value = 1'b1;
    dir_rows.push_back(row);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        repeat (row.reps) send_item(row.it, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      ie = 3'($urandom_range(7));
      case (ph)
        0: begin lyc_val = 8'd0;   ie = 3'b111; end
        1: begin lyc_val = 8'd255; ie = 3'b000; end
        2: lyc_val = 8'd144;
        3: lyc_val = 8'd152;
        4: lyc_val = 8'($urandom_range(143, 1));
        default: lyc_val = 8'd0;
      endcase
      write_reg(REG_LYC, lyc_val);
      write_reg(REG_HBLANK_IE, {7'd0, ie[2]});
      write_reg(REG_VBLANK_IE, {7'd0, ie[1]});
      write_reg(REG_OAM_IE, {7'd0, ie[0]});
      tx_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 68 : 0;
      rx_idle_pct = (ph < 2) ? 68 : (ph < 4) ? 16 : 0;
      // long hold-off on the result side while items keep coming
      if (ph == 4)
        stall_req = 1'b1;
      counted = 0;
      while (counted < 160) begin
        it = random_item();
        if (it.req_type == REQ_WRITE || tm_lcd_on)
          counted++;
        send_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lmt_pkg.sv
hw/rtl/lmt_core.sv
hw/rtl/lcd_mode_line_timer.sv
hw/rtl/lmt_checker.sv
test/lcd_mode_line_timer_tb.sv
